[rtl/pfc_pkg.sv]
// Shared types, constants and square helpers for the Playfair digraph cipher unit.
package pfc_pkg;

    localparam int SIDE   = 5;
    localparam int CODE_W = 5;
    localparam int ROW_W  = SIDE * CODE_W;
    localparam int POS_W  = 3;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [CODE_W-1:0] CODE_I = 5'd8;
    localparam logic [CODE_W-1:0] CODE_J = 5'd9;

    localparam logic [POS_W-1:0] POS_0 = 3'd0;
    localparam logic [POS_W-1:0] POS_1 = 3'd1;
    localparam logic [POS_W-1:0] POS_2 = 3'd2;
    localparam logic [POS_W-1:0] POS_3 = 3'd3;
    localparam logic [POS_W-1:0] POS_4 = 3'd4;

    typedef logic [SIDE-1:0][ROW_W-1:0] square_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } loc_t;

    function automatic logic [CODE_W-1:0] cell_at(input square_t sq,
                                                  input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
        logic [ROW_W-1:0] row_bits;
        row_bits = sq[r];
        return row_bits[c*CODE_W +: CODE_W];
    endfunction

    // wraps within 0..SIDE-1
    function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
                                                  input logic back);
        logic [POS_W-1:0] q;
        unique case (p)
            POS_0:   q = back ? POS_4 : POS_1;
            POS_1:   q = back ? POS_0 : POS_2;
            POS_2:   q = back ? POS_1 : POS_3;
            POS_3:   q = back ? POS_2 : POS_4;
            POS_4:   q = back ? POS_3 : POS_0;
            default: q = POS_0;
        endcase
        return q;
    endfunction

endpackage

[rtl/pfc_locate.sv]
// Parallel lookup of one letter code in the key square; last match in row-major order wins.
module pfc_locate (
    input  pfc_pkg::square_t               square,
    input  logic [pfc_pkg::CODE_W-1:0]     code,
    output pfc_pkg::loc_t                  loc
);
    import pfc_pkg::*;

    always_comb
    begin
        loc = '0;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (square[r][c*CODE_W +: CODE_W] == code)
                begin
                    loc.hit = 1'b1;
                    loc.row = POS_W'(r);
                    loc.col = POS_W'(c);
                end
            end
        end
    end

endmodule

[rtl/pfc_xform.sv]
// Digraph row shift, column shift, rectangle swap or pass-through.
module pfc_xform (
    input  pfc_pkg::square_t               square,
    input  logic                           back,
    input  logic [pfc_pkg::CODE_W-1:0]     first_raw,
    input  logic [pfc_pkg::CODE_W-1:0]     second_raw,
    input  pfc_pkg::loc_t                  loc_a,
    input  pfc_pkg::loc_t                  loc_b,
    output logic [pfc_pkg::CODE_W-1:0]     res_first,
    output logic [pfc_pkg::CODE_W-1:0]     res_second,
    output logic                           res_found
);
    import pfc_pkg::*;

    always_comb
    begin
        res_found = loc_a.hit && loc_b.hit;
        priority if (!res_found)
        begin
            res_first  = first_raw;
            res_second = second_raw;
        end
        else if (loc_a.row == loc_b.row)
        begin
            res_first  = cell_at(square, loc_a.row, step_pos(loc_a.col, back));
            res_second = cell_at(square, loc_b.row, step_pos(loc_b.col, back));
        end
        else if (loc_a.col == loc_b.col)
        begin
            res_first  = cell_at(square, step_pos(loc_a.row, back), loc_a.col);
            res_second = cell_at(square, step_pos(loc_b.row, back), loc_b.col);
        end
        else
        begin
            res_first  = cell_at(square, loc_a.row, loc_b.col);
            res_second = cell_at(square, loc_b.row, loc_a.col);
        end
    end

endmodule

[rtl/playfair_digraph_cipher_unit.sv]
// Top level of the Playfair digraph cipher unit: key square registers, request and result stages.
//
// One digraph request is taken in every clock cycle; busy never rises. A request is
// captured in the input register at the edge where start is high, and its result is
// presented on out_first, out_second and found with done high for one cycle,
// registered at the next edge: the key square lookup and substitution sit between those two
// registers. The receiver cannot stall, so a result must be taken in its done cycle.
// The key square is five APB registers at byte addresses 0x00 to 0x10, reset to zero,
// to be written only while no request is in flight.
module playfair_digraph_cipher_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [pfc_pkg::CODE_W-1:0]     first_letter,
    input  logic [pfc_pkg::CODE_W-1:0]     second_letter,
    output logic                           done,
    output logic [pfc_pkg::CODE_W-1:0]     out_first,
    output logic [pfc_pkg::CODE_W-1:0]     out_second,
    output logic                           found,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfc_pkg::ADDR_W-1:0]     paddr,
    input  logic [pfc_pkg::DATA_W-1:0]     pwdata,
    output logic [pfc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import pfc_pkg::*;

    localparam int IDX_W = ADDR_W - 2;

    square_t             square_reg;
    square_t             square_next;

    logic                req_valid_reg;
    logic                req_func_reg;
    logic [CODE_W-1:0]   req_first_reg;
    logic [CODE_W-1:0]   req_second_reg;

    logic                done_reg;
    logic [CODE_W-1:0]   out_first_reg;
    logic [CODE_W-1:0]   out_second_reg;
    logic                found_reg;

    logic [IDX_W-1:0]    reg_idx;
    logic                cfg_write;
    logic [CODE_W-1:0]   key_first;
    logic [CODE_W-1:0]   key_second;
    loc_t                loc_a;
    loc_t                loc_b;
    logic [CODE_W-1:0]   res_first;
    logic [CODE_W-1:0]   res_second;
    logic                res_found;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        square_next = square_reg;
        for (int i = 0; i < SIDE; i++)
        begin
            if (cfg_write && (reg_idx == IDX_W'(i)))
            begin
                square_next[i] = pwdata[ROW_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < SIDE; i++)
        begin
            if (reg_idx == IDX_W'(i))
            begin
                prdata = DATA_W'(square_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg <= '0;
        end
        else
        begin
            square_reg <= square_next;
        end
    end

    // request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_func_reg   <= func;
            req_first_reg  <= first_letter;
            req_second_reg <= second_letter;
        end
    end

    // j folds to i before lookup
    assign key_first  = (req_first_reg  == CODE_J) ? CODE_I : req_first_reg;
    assign key_second = (req_second_reg == CODE_J) ? CODE_I : req_second_reg;

    pfc_locate u_locate_a (
        .square (square_reg),
        .code   (key_first),
        .loc    (loc_a)
    );

    pfc_locate u_locate_b (
        .square (square_reg),
        .code   (key_second),
        .loc    (loc_b)
    );

    pfc_xform u_xform (
        .square     (square_reg),
        .back       (req_func_reg),
        .first_raw  (req_first_reg),
        .second_raw (req_second_reg),
        .loc_a      (loc_a),
        .loc_b      (loc_b),
        .res_first  (res_first),
        .res_second (res_second),
        .res_found  (res_found)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            out_first_reg  <= res_first;
            out_second_reg <= res_second;
            found_reg      <= res_found;
        end
    end

    assign done       = done_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign found      = found_reg;

endmodule

[sim/pfc_checker.sv]
// Checker for the Playfair digraph cipher unit: follows key square writes and scores every result.
module pfc_checker
    import pfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              func,
    input  logic [CODE_W-1:0] first_letter,
    input  logic [CODE_W-1:0] second_letter,
    input  logic              done,
    input  logic [CODE_W-1:0] out_first,
    input  logic [CODE_W-1:0] out_second,
    input  logic              found,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [CODE_W-1:0] first;
        logic [CODE_W-1:0] second;
        logic              hit;
    } digraph_t;

    logic [ROW_W-1:0] key_row [SIDE];
    digraph_t         digraph_queue [$];

    function automatic logic [CODE_W-1:0] square_cell(input int r, input int c);
        logic [ROW_W-1:0] bits;
        bits = key_row[r];
        return bits[c*CODE_W +: CODE_W];
    endfunction

    // last match in row-major order wins
    function automatic bit find_letter(input logic [CODE_W-1:0] code,
                                       output int r, output int c);
        bit hit;
        hit = 1'b0;
        r   = 0;
        c   = 0;
        for (int i = 0; i < SIDE; i++)
            for (int k = 0; k < SIDE; k++)
                if (square_cell(i, k) == code)
                begin
                    r   = i;
                    c   = k;
                    hit = 1'b1;
                end
        return hit;
    endfunction

    function automatic int wrap_step(input int p, input logic back);
        return back ? (p + SIDE - 1) % SIDE : (p + 1) % SIDE;
    endfunction

    function automatic digraph_t encipher_digraph(input logic back,
                                                  input logic [CODE_W-1:0] a,
                                                  input logic [CODE_W-1:0] b);
        digraph_t          res;
        logic [CODE_W-1:0] ka;
        logic [CODE_W-1:0] kb;
        int                ra, ca, rb, cb;
        bit                fa, fb;
        ka = (a == CODE_J) ? CODE_I : a;
        kb = (b == CODE_J) ? CODE_I : b;
        fa = find_letter(ka, ra, ca);
        fb = find_letter(kb, rb, cb);
        if (!(fa && fb))
        begin
            res.first  = a;
            res.second = b;
            res.hit    = 1'b0;
        end
        else if (ra == rb)
        begin
            res.first  = square_cell(ra, wrap_step(ca, back));
            res.second = square_cell(rb, wrap_step(cb, back));
            res.hit    = 1'b1;
        end
        else if (ca == cb)
        begin
            res.first  = square_cell(wrap_step(ra, back), ca);
            res.second = square_cell(wrap_step(rb, back), cb);
            res.hit    = 1'b1;
        end
        else
        begin
            res.first  = square_cell(ra, cb);
            res.second = square_cell(rb, ca);
            res.hit    = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digraph_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < SIDE; r++)
                key_row[r] = '0;
            digraph_queue.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (digraph_queue.size() == 0)
                begin
                    $error("unexpected result: out_first %0d out_second %0d found %0b",
                           out_first, out_second, found);
                    mismatches++;
                end
                else
                begin
                    want = digraph_queue.pop_front();
                    if (out_first !== want.first)
                    begin
                        $error("out_first: expected %0d, actual %0d", want.first, out_first);
                        mismatches++;
                    end
                    if (out_second !== want.second)
                    begin
                        $error("out_second: expected %0d, actual %0d", want.second, out_second);
                        mismatches++;
                    end
                    if (found !== want.hit)
                    begin
                        $error("found: expected %0b, actual %0b", want.hit, found);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                digraph_queue.push_back(encipher_digraph(func, first_letter, second_letter));
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] < SIDE)
                key_row[paddr[ADDR_W-1:2]] = pwdata[ROW_W-1:0];
            outstanding <= digraph_queue.size();
        end
    end

endmodule

[sim/tb_top.sv]
// Testbench top: drives digraph requests and key square writes into the cipher unit.
module tb_top;
    import pfc_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int MAX_GAP         = 6;
    localparam int STEADY_SPAN     = 32;
    localparam int TAIL_CYCLES     = 8;
    localparam int REG_STRIDE      = 4;
    localparam int NUM_PHASES      = 7;
    localparam int REPEAT_CODES    = 11;
    localparam int MAX_CODE        = 31;
    localparam int MAX_LETTER      = 25;

    typedef enum logic { OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1 } op_e;
    typedef enum int { SQ_ALPHABET, SQ_SHUFFLED, SQ_REPEATS, SQ_RAW, SQ_ZERO, SQ_FULL }
        square_kind_e;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic              func          = 1'b0;
    logic [CODE_W-1:0] first_letter  = '0;
    logic [CODE_W-1:0] second_letter = '0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic              busy;
    logic              done;
    logic [CODE_W-1:0] out_first;
    logic [CODE_W-1:0] out_second;
    logic              found;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                check_failures;
    int                pending_results;
    int unsigned       cycle_count = 0;
    bit                steady      = 1'b0;
    logic [ROW_W-1:0]  square_plan [SIDE];
    square_kind_e      phase_kinds [NUM_PHASES] = '{SQ_SHUFFLED, SQ_REPEATS, SQ_FULL, SQ_RAW,
                                                    SQ_ZERO, SQ_SHUFFLED, SQ_REPEATS};

    playfair_digraph_cipher_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .first_letter  (first_letter),
        .second_letter (second_letter),
        .done          (done),
        .out_first     (out_first),
        .out_second    (out_second),
        .found         (found),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    pfc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .first_letter  (first_letter),
        .second_letter (second_letter),
        .done          (done),
        .out_first     (out_first),
        .out_second    (out_second),
        .found         (found),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (check_failures),
        .outstanding   (pending_results)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_row(input int r, input logic [ROW_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(r * REG_STRIDE);
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_square(input square_kind_e kind);
        logic [CODE_W-1:0] cells [SIDE*SIDE];
        logic [CODE_W-1:0] swap;
        int                code;
        int                k;
        code = 0;
        foreach (cells[i])
        begin
            if (code == CODE_J)
                code++;
            cells[i] = CODE_W'(code);
            code++;
        end
        if (kind == SQ_SHUFFLED)
            for (int i = SIDE*SIDE - 1; i > 0; i--)
            begin
                k        = $urandom_range(0, i);
                swap     = cells[i];
                cells[i] = cells[k];
                cells[k] = swap;
            end
        if (kind == SQ_REPEATS)
            foreach (cells[i])
                cells[i] = CODE_W'($urandom_range(0, REPEAT_CODES));
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
                square_plan[r][c*CODE_W +: CODE_W] = cells[r*SIDE + c];
            case (kind)
                SQ_RAW:  square_plan[r] = ROW_W'($urandom());
                SQ_ZERO: square_plan[r] = '0;
                SQ_FULL: square_plan[r] = '1;
                default: ;
            endcase
            write_row(r, square_plan[r]);
        end
    endtask

    task automatic send_digraph(input op_e op, input logic [CODE_W-1:0] a,
                                input logic [CODE_W-1:0] b, input bit hold);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0 || hold)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            if (hold)
                wait_drained();
        end
        start         <= 1'b1;
        func          <= op;
        first_letter  <= a;
        second_letter <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [CODE_W-1:0] plan_letter(input int r, input int c);
        logic [CODE_W-1:0] code;
        code = square_plan[r][c*CODE_W +: CODE_W];
        if (code == CODE_I && $urandom_range(0, 1))
            code = CODE_J;
        return code;
    endfunction

    function automatic logic [CODE_W-1:0] noise_letter();
        return CODE_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, MAX_CODE)
                                                 : $urandom_range(0, MAX_LETTER));
    endfunction

    // mostly letters from the square, biased toward shared rows and columns
    task automatic pick_digraph(output logic [CODE_W-1:0] a, output logic [CODE_W-1:0] b);
        int r1, c1, r2, c2, mode;
        r1   = $urandom_range(0, SIDE-1);
        c1   = $urandom_range(0, SIDE-1);
        mode = $urandom_range(0, 3);
        r2   = (mode == 0) ? r1 : $urandom_range(0, SIDE-1);
        c2   = (mode == 1) ? c1 : $urandom_range(0, SIDE-1);
        a    = plan_letter(r1, c1);
        b    = plan_letter(r2, c2);
        if ($urandom_range(0, 6) == 0)
            a = noise_letter();
        if ($urandom_range(0, 6) == 0)
            b = noise_letter();
    endtask

    initial
    begin
        logic [CODE_W-1:0] a;
        logic [CODE_W-1:0] b;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero square out of reset
        send_digraph(OP_ENCRYPT, 5'd0, 5'd0, 1'b0);
        send_digraph(OP_DECRYPT, 5'd0, 5'd0, 1'b0);
        send_digraph(OP_ENCRYPT, 5'd5, 5'd0, 1'b0);
        send_digraph(OP_DECRYPT, 5'd31, 5'd0, 1'b0);
        start <= 1'b0;
        wait_drained();

        program_square(SQ_ALPHABET);
        send_digraph(OP_ENCRYPT, 5'd0, 5'd4, 1'b0);   // same row, wrap right
        send_digraph(OP_DECRYPT, 5'd0, 5'd4, 1'b0);   // same row, wrap left
        send_digraph(OP_ENCRYPT, 5'd0, 5'd21, 1'b0);  // same column, wrap down
        send_digraph(OP_DECRYPT, 5'd0, 5'd21, 1'b0);  // same column, wrap up
        send_digraph(OP_ENCRYPT, 5'd7, 5'd17, 1'b0);  // rectangle
        send_digraph(OP_DECRYPT, 5'd7, 5'd17, 1'b0);
        send_digraph(OP_ENCRYPT, CODE_J, 5'd0, 1'b0);
        send_digraph(OP_ENCRYPT, CODE_J, CODE_J, 1'b0);
        send_digraph(OP_DECRYPT, CODE_I, CODE_J, 1'b0);
        send_digraph(OP_ENCRYPT, 5'd25, 5'd25, 1'b0);
        send_digraph(OP_ENCRYPT, 5'd26, 5'd0, 1'b0);  // first letter missing
        send_digraph(OP_ENCRYPT, 5'd0, 5'd31, 1'b0);  // second letter missing
        send_digraph(OP_DECRYPT, 5'd31, 5'd31, 1'b0);
        send_digraph(OP_ENCRYPT, 5'd25, 5'd0, 1'b0);
        send_digraph(OP_DECRYPT, 5'd0, 5'd25, 1'b0);
        start <= 1'b0;
        wait_drained();

        foreach (phase_kinds[p])
        begin
            program_square(phase_kinds[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (i % STEADY_SPAN == 0)
                    steady = ($urandom_range(0, 2) == 0);
                pick_digraph(a, b);
                send_digraph(op_e'($urandom_range(0, 1)), a, b, $urandom_range(0, 39) == 0);
            end
            start <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (check_failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[playfair_digraph_cipher_unit.f]
rtl/pfc_pkg.sv
rtl/pfc_locate.sv
rtl/pfc_xform.sv
rtl/playfair_digraph_cipher_unit.sv
sim/pfc_checker.sv
sim/tb_top.sv
